@@ rtl/logrid_pkg.sv @@
`default_nettype none

package logrid_pkg;

  localparam int POS_W     = 24;
  localparam int LO_W      = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_OUT_W = 13;

  localparam logic signed [LO_W-1:0] HIT_INC_RST   = 16'sd1661;
  localparam logic signed [LO_W-1:0] MISS_INC_RST  = -16'sd3471;
  localparam logic signed [LO_W-1:0] MIN_LO_RST    = -16'sd8161;
  localparam logic signed [LO_W-1:0] MAX_LO_RST    = 16'sd14238;
  localparam logic signed [LO_W-1:0] OCC_THR_RST   = 16'sd1661;
  localparam logic signed [LO_W-1:0] PRIOR_LO_RST  = 16'sd0;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OCC_UNKNOWN  = 2'd0,
    OCC_FREE     = 2'd1,
    OCC_OCCUPIED = 2'd2
  } occ_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_INC    = 3'd0,
    REG_MISS_INC   = 3'd1,
    REG_MIN_LO     = 3'd2,
    REG_MAX_LO     = 3'd3,
    REG_OCC_THR    = 3'd4,
    REG_PRIOR_LO   = 3'd5,
    REG_ORIGIN_COL = 3'd6,
    REG_ORIGIN_ROW = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOCATE,
    S_RD,
    S_PT_CHK,
    S_RD_CHK,
    S_LST_RD,
    S_CEL_RD,
    S_MISS,
    S_HIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [LO_W-1:0] min_lo;
    logic signed [LO_W-1:0] max_lo;
    logic signed [LO_W-1:0] thr;
  } lims_t;

endpackage

`default_nettype wire

@@ rtl/logrid_ram.sv @@
`default_nettype none

module logrid_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/logrid_incr.sv @@
`default_nettype none

module logrid_incr #(
  parameter int LOG_ODDS_BITS = 16
) (
  input  wire logic signed [(LOG_ODDS_BITS > 16 ? LOG_ODDS_BITS : 16)-1:0] cur_i,
  input  wire logic signed [logrid_pkg::LO_W-1:0]                         inc_i,
  input  wire logrid_pkg::lims_t                                          lims_i,
  output logic signed [LOG_ODDS_BITS-1:0]                                 val_o,
  output logrid_pkg::occ_t                                                occ_o
);

  localparam int VW = (LOG_ODDS_BITS > 16) ? LOG_ODDS_BITS : 16;
  localparam int SW = VW + 1;
  localparam longint SAT_HI_L = (64'sd1 <<< (LOG_ODDS_BITS - 1)) - 64'sd1;
  localparam longint SAT_LO_L = -(64'sd1 <<< (LOG_ODDS_BITS - 1));
  localparam logic signed [SW-1:0] SAT_HI = SW'(SAT_HI_L);
  localparam logic signed [SW-1:0] SAT_LO = SW'(SAT_LO_L);

  logic signed [logrid_pkg::LO_W-1:0] mn;
  logic signed [logrid_pkg::LO_W-1:0] mx;
  logic signed [logrid_pkg::LO_W-1:0] thr;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] s_max;
  logic signed [SW-1:0] s_min;
  logic signed [SW-1:0] s_sat;

  assign mn  = lims_i.min_lo;
  assign mx  = lims_i.max_lo;
  assign thr = lims_i.thr;

  // The upper bound is applied first, so a lower bound above the upper one wins.
  always_comb begin
    sum   = SW'(cur_i) + SW'(inc_i);
    s_max = (sum > SW'(mx)) ? SW'(mx) : sum;
    s_min = (s_max < SW'(mn)) ? SW'(mn) : s_max;
    if (s_min > SAT_HI) begin
      s_sat = SAT_HI;
    end else if (s_min < SAT_LO) begin
      s_sat = SAT_LO;
    end else begin
      s_sat = s_min;
    end
    val_o = s_sat[LOG_ODDS_BITS-1:0];
    occ_o = (s_sat >= SW'(thr)) ? logrid_pkg::OCC_OCCUPIED : logrid_pkg::OCC_FREE;
  end

endmodule

`default_nettype wire

@@ rtl/log_odds_occupancy_grid_update_top.sv @@
`default_nettype none

// Log-odds occupancy grid. Each cell (log-odds, occupancy, free and obstacle
// marks) lives in one word of a MAP_WIDTH x MAP_HEIGHT synchronous memory, and
// touched cells are queued in a MAX_TOUCHED-entry list memory. After reset a
// clearing pass writes every cell word, one per cycle, so the block takes no
// transaction until that pass ends; configuration writes are taken
// throughout. Items are handled one at a time by a read-modify-write sequencer
// on the cell memory: an add-point or read-cell transaction inside the map
// steps through locate, read and check before its result is emitted, a
// position outside the map, a point after an overflow or an unused action code
// goes from locate straight to emit, and a commit runs list read, cell read,
// miss step and hit step with write-back for each touched cell (all sharing one
// increment and clamp unit). Results sit in an output register, so a new
// transaction is accepted while the previous result waits.
module log_odds_occupancy_grid_update_top #(
  parameter int MAP_WIDTH     = 1024,
  parameter int MAP_HEIGHT    = 1024,
  parameter int MAX_TOUCHED   = 4096,
  parameter int LOG_ODDS_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [logrid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [logrid_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            in_action,
  input  wire logic signed [logrid_pkg::POS_W-1:0]   in_point_col,
  input  wire logic signed [logrid_pkg::POS_W-1:0]   in_point_row,
  input  wire logic [7:0]                            in_mask_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [1:0]                                 out_status,
  output logic [1:0]                                 out_occupancy,
  output logic signed [logrid_pkg::LO_W-1:0]         out_cell_log_odds,
  output logic [logrid_pkg::CNT_OUT_W-1:0]           out_cells_updated,
  output logic                                       out_overflow_seen
);

  localparam int CELLS   = MAP_WIDTH * MAP_HEIGHT;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int COL_W   = $clog2(MAP_WIDTH);
  localparam int ROW_W   = $clog2(MAP_HEIGHT);
  localparam int LIST_AW = $clog2(MAX_TOUCHED);
  localparam int CNT_W   = $clog2(MAX_TOUCHED + 1);
  localparam int LOB     = LOG_ODDS_BITS;
  localparam int VW      = (LOB > 16) ? LOB : 16;
  localparam int CW      = LOB + 4;
  localparam int DW      = logrid_pkg::POS_W + 1;

  localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] MW_C      = CELL_AW'(MAP_WIDTH);
  localparam logic [DW-1:0]      MW_D      = DW'(MAP_WIDTH);
  localparam logic [DW-1:0]      MH_D      = DW'(MAP_HEIGHT);
  localparam logic [CNT_W-1:0]   MAX_C     = CNT_W'(MAX_TOUCHED);

  // Configuration registers.
  logic signed [logrid_pkg::LO_W-1:0]  hit_inc_r;
  logic signed [logrid_pkg::LO_W-1:0]  miss_inc_r;
  logic signed [logrid_pkg::LO_W-1:0]  min_lo_r;
  logic signed [logrid_pkg::LO_W-1:0]  max_lo_r;
  logic signed [logrid_pkg::LO_W-1:0]  thr_r;
  logic signed [logrid_pkg::LO_W-1:0]  prior_r;
  logic signed [logrid_pkg::POS_W-1:0] org_col_r;
  logic signed [logrid_pkg::POS_W-1:0] org_row_r;

  // Sequencer state.
  logrid_pkg::state_t  state_r, state_nxt;
  logrid_pkg::act_t    act_r, act_nxt;
  logic                obs_r, obs_nxt;
  logic [DW-1:0]       dcol_r, dcol_nxt;
  logic [DW-1:0]       drow_r, drow_nxt;
  logic [CELL_AW-1:0]  idx_r, idx_nxt;
  logic [CELL_AW-1:0]  cidx_r, cidx_nxt;
  logic [CELL_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic                ovf_r, ovf_nxt;
  logic                free_mk_r, free_mk_nxt;
  logic                obs_mk_r, obs_mk_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logrid_pkg::occ_t    occ_r, occ_nxt;

  logrid_pkg::status_t               res_status_r, res_status_nxt;
  logrid_pkg::occ_t                  res_occ_r, res_occ_nxt;
  logic signed [logrid_pkg::LO_W-1:0] res_lo_r, res_lo_nxt;
  logic [logrid_pkg::CNT_OUT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic                              res_ovf_r, res_ovf_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logrid_pkg::status_t               out_status_r;
  logrid_pkg::occ_t                  out_occ_r;
  logic signed [logrid_pkg::LO_W-1:0] out_lo_r;
  logic [logrid_pkg::CNT_OUT_W-1:0]  out_cnt_r;
  logic                              out_ovf_r;

  // Memory ports.
  logic                cell_we, cell_re;
  logic [CELL_AW-1:0]  cell_waddr, cell_raddr;
  logic [CW-1:0]       cell_wdata, cell_rdata;
  logic                list_we, list_re;
  logic [LIST_AW-1:0]  list_waddr, list_raddr;
  logic [CELL_AW-1:0]  list_wdata, list_rdata;

  // Cell word fields.
  logic signed [LOB-1:0] rd_lo;
  logrid_pkg::occ_t      rd_occ;
  logic                  rd_free;
  logic                  rd_obs;
  logic signed [VW-1:0]  rd_cur;

  logic                  accept;
  logic                  emit_go;
  logic                  in_map;
  logic [CELL_AW-1:0]    loc_idx;
  logic                  unmarked;
  logic                  list_full;
  logic                  last_entry;

  logic signed [VW-1:0]              inc_cur;
  logic signed [logrid_pkg::LO_W-1:0] inc_val;
  logrid_pkg::lims_t                 lims;
  logic signed [LOB-1:0]             inc_res;
  logrid_pkg::occ_t                  inc_occ;

  assign accept  = in_valid && !in_stall;
  assign emit_go = (state_r == logrid_pkg::S_EMIT) && (!out_valid_r || !out_stall);

  assign rd_lo   = cell_rdata[LOB-1:0];
  assign rd_occ  = logrid_pkg::occ_t'(cell_rdata[LOB+1:LOB]);
  assign rd_free = cell_rdata[LOB+2];
  assign rd_obs  = cell_rdata[LOB+3];
  assign rd_cur  = (rd_occ == logrid_pkg::OCC_UNKNOWN) ? VW'(prior_r) : VW'(rd_lo);

  assign in_map = !dcol_r[DW-1] && (dcol_r < MW_D) && !drow_r[DW-1] && (drow_r < MH_D);
  assign loc_idx = CELL_AW'(drow_r[ROW_W-1:0]) * MW_C + CELL_AW'(dcol_r[COL_W-1:0]);

  assign unmarked   = !rd_free && !rd_obs;
  assign list_full  = (cnt_r == MAX_C);
  assign last_entry = ((ptr_r + 1'b1) == cnt_r);

  assign lims.min_lo = min_lo_r;
  assign lims.max_lo = max_lo_r;
  assign lims.thr    = thr_r;

  logrid_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_cell_mem (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  logrid_ram #(
    .WIDTH (CELL_AW),
    .DEPTH (MAX_TOUCHED)
  ) u_list_mem (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  logrid_incr #(
    .LOG_ODDS_BITS (LOG_ODDS_BITS)
  ) u_incr (
    .cur_i  (inc_cur),
    .inc_i  (inc_val),
    .lims_i (lims),
    .val_o  (inc_res),
    .occ_o  (inc_occ)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_inc_r  <= logrid_pkg::HIT_INC_RST;
      miss_inc_r <= logrid_pkg::MISS_INC_RST;
      min_lo_r   <= logrid_pkg::MIN_LO_RST;
      max_lo_r   <= logrid_pkg::MAX_LO_RST;
      thr_r      <= logrid_pkg::OCC_THR_RST;
      prior_r    <= logrid_pkg::PRIOR_LO_RST;
      org_col_r  <= '0;
      org_row_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        logrid_pkg::REG_HIT_INC:    hit_inc_r  <= cfg_wdata[logrid_pkg::LO_W-1:0];
        logrid_pkg::REG_MISS_INC:   miss_inc_r <= cfg_wdata[logrid_pkg::LO_W-1:0];
        logrid_pkg::REG_MIN_LO:     min_lo_r   <= cfg_wdata[logrid_pkg::LO_W-1:0];
        logrid_pkg::REG_MAX_LO:     max_lo_r   <= cfg_wdata[logrid_pkg::LO_W-1:0];
        logrid_pkg::REG_OCC_THR:    thr_r      <= cfg_wdata[logrid_pkg::LO_W-1:0];
        logrid_pkg::REG_PRIOR_LO:   prior_r    <= cfg_wdata[logrid_pkg::LO_W-1:0];
        logrid_pkg::REG_ORIGIN_COL: org_col_r  <= cfg_wdata;
        logrid_pkg::REG_ORIGIN_ROW: org_row_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      logrid_pkg::S_CLEAR: begin
        if (clr_addr_r == CELL_LAST) begin
          state_nxt = logrid_pkg::S_IDLE;
        end
      end
      logrid_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = logrid_pkg::S_LOCATE;
        end
      end
      logrid_pkg::S_LOCATE: begin
        unique case (act_r)
          logrid_pkg::ACT_ADD: begin
            state_nxt = (ovf_r || !in_map) ? logrid_pkg::S_EMIT : logrid_pkg::S_RD;
          end
          logrid_pkg::ACT_READ: begin
            state_nxt = in_map ? logrid_pkg::S_RD : logrid_pkg::S_EMIT;
          end
          logrid_pkg::ACT_COMMIT: begin
            state_nxt = (cnt_r == '0) ? logrid_pkg::S_EMIT : logrid_pkg::S_LST_RD;
          end
          default: state_nxt = logrid_pkg::S_EMIT;
        endcase
      end
      logrid_pkg::S_RD: begin
        state_nxt = (act_r == logrid_pkg::ACT_ADD) ? logrid_pkg::S_PT_CHK
                                                   : logrid_pkg::S_RD_CHK;
      end
      logrid_pkg::S_PT_CHK: state_nxt = logrid_pkg::S_EMIT;
      logrid_pkg::S_RD_CHK: state_nxt = logrid_pkg::S_EMIT;
      logrid_pkg::S_LST_RD: state_nxt = logrid_pkg::S_CEL_RD;
      logrid_pkg::S_CEL_RD: state_nxt = logrid_pkg::S_MISS;
      logrid_pkg::S_MISS:   state_nxt = logrid_pkg::S_HIT;
      logrid_pkg::S_HIT: begin
        state_nxt = last_entry ? logrid_pkg::S_EMIT : logrid_pkg::S_LST_RD;
      end
      logrid_pkg::S_EMIT: begin
        if (emit_go) begin
          state_nxt = logrid_pkg::S_IDLE;
        end
      end
      default: state_nxt = logrid_pkg::S_IDLE;
    endcase
  end

  // Memory controls, increment unit inputs and handshake.
  always_comb begin
    in_stall   = (state_r != logrid_pkg::S_IDLE);
    cell_we    = 1'b0;
    cell_waddr = idx_r;
    cell_wdata = cell_rdata;
    cell_re    = 1'b0;
    cell_raddr = idx_r;
    list_we    = 1'b0;
    list_waddr = cnt_r[LIST_AW-1:0];
    list_wdata = idx_r;
    list_re    = 1'b0;
    list_raddr = ptr_r[LIST_AW-1:0];
    inc_cur    = rd_cur;
    inc_val    = miss_inc_r;
    unique case (state_r)
      logrid_pkg::S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr_r;
        cell_wdata = {1'b0, 1'b0, logrid_pkg::OCC_UNKNOWN, {LOB{1'b0}}};
      end
      logrid_pkg::S_RD: begin
        cell_re = 1'b1;
      end
      logrid_pkg::S_PT_CHK: begin
        if (!(unmarked && list_full)) begin
          cell_we = 1'b1;
          if (obs_r) begin
            cell_wdata[LOB+3] = 1'b1;
          end else begin
            cell_wdata[LOB+2] = 1'b1;
          end
        end
        list_we = unmarked && !list_full;
      end
      logrid_pkg::S_LST_RD: begin
        list_re = 1'b1;
      end
      logrid_pkg::S_CEL_RD: begin
        cell_re    = 1'b1;
        cell_raddr = list_rdata;
      end
      logrid_pkg::S_HIT: begin
        inc_cur    = val_r;
        inc_val    = hit_inc_r;
        cell_we    = 1'b1;
        cell_waddr = cidx_r;
        if (obs_mk_r) begin
          cell_wdata = {1'b0, 1'b0, inc_occ, inc_res};
        end else begin
          cell_wdata = {1'b0, 1'b0, occ_r, val_r[LOB-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    act_nxt        = act_r;
    obs_nxt        = obs_r;
    dcol_nxt       = dcol_r;
    drow_nxt       = drow_r;
    idx_nxt        = idx_r;
    cidx_nxt       = cidx_r;
    clr_addr_nxt   = clr_addr_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    ovf_nxt        = ovf_r;
    free_mk_nxt    = free_mk_r;
    obs_mk_nxt     = obs_mk_r;
    val_nxt        = val_r;
    occ_nxt        = occ_r;
    res_status_nxt = res_status_r;
    res_occ_nxt    = res_occ_r;
    res_lo_nxt     = res_lo_r;
    res_cnt_nxt    = res_cnt_r;
    res_ovf_nxt    = res_ovf_r;
    unique case (state_r)
      logrid_pkg::S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      logrid_pkg::S_IDLE: begin
        if (accept) begin
          act_nxt        = logrid_pkg::act_t'(in_action);
          obs_nxt        = in_mask_value[7];
          dcol_nxt       = DW'(in_point_col) - DW'(org_col_r);
          drow_nxt       = DW'(in_point_row) - DW'(org_row_r);
          res_status_nxt = logrid_pkg::ST_OK;
          res_occ_nxt    = logrid_pkg::OCC_UNKNOWN;
          res_lo_nxt     = '0;
          res_cnt_nxt    = '0;
          res_ovf_nxt    = 1'b0;
        end
      end
      logrid_pkg::S_LOCATE: begin
        idx_nxt = loc_idx;
        ptr_nxt = '0;
        unique case (act_r)
          logrid_pkg::ACT_ADD: begin
            if (ovf_r) begin
              res_status_nxt = logrid_pkg::ST_IGNORED;
            end else if (!in_map) begin
              ovf_nxt        = 1'b1;
              res_status_nxt = logrid_pkg::ST_OUTSIDE;
            end
          end
          logrid_pkg::ACT_READ: begin
            if (!in_map) begin
              res_status_nxt = logrid_pkg::ST_OUTSIDE;
            end
          end
          logrid_pkg::ACT_COMMIT: begin
            if (cnt_r == '0) begin
              res_ovf_nxt = ovf_r;
              ovf_nxt     = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      logrid_pkg::S_PT_CHK: begin
        if (unmarked) begin
          if (list_full) begin
            res_status_nxt = logrid_pkg::ST_FULL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      logrid_pkg::S_RD_CHK: begin
        res_occ_nxt = rd_occ;
        res_lo_nxt  = (rd_occ == logrid_pkg::OCC_UNKNOWN) ? prior_r
                                                          : logrid_pkg::LO_W'(rd_lo);
      end
      logrid_pkg::S_CEL_RD: begin
        cidx_nxt = list_rdata;
      end
      logrid_pkg::S_MISS: begin
        free_mk_nxt = rd_free;
        obs_mk_nxt  = rd_obs;
        occ_nxt     = inc_occ;
        val_nxt     = rd_free ? VW'(inc_res) : rd_cur;
      end
      logrid_pkg::S_HIT: begin
        ptr_nxt = ptr_r + 1'b1;
        if (last_entry) begin
          res_cnt_nxt = logrid_pkg::CNT_OUT_W'(cnt_r);
          res_ovf_nxt = ovf_r;
          cnt_nxt     = '0;
          ovf_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = emit_go ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= logrid_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    obs_r        <= obs_nxt;
    dcol_r       <= dcol_nxt;
    drow_r       <= drow_nxt;
    idx_r        <= idx_nxt;
    cidx_r       <= cidx_nxt;
    ptr_r        <= ptr_nxt;
    free_mk_r    <= free_mk_nxt;
    obs_mk_r     <= obs_mk_nxt;
    val_r        <= val_nxt;
    occ_r        <= occ_nxt;
    res_status_r <= res_status_nxt;
    res_occ_r    <= res_occ_nxt;
    res_lo_r     <= res_lo_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_ovf_r    <= res_ovf_nxt;
    if (emit_go) begin
      out_status_r <= res_status_r;
      out_occ_r    <= res_occ_r;
      out_lo_r     <= res_lo_r;
      out_cnt_r    <= res_cnt_r;
      out_ovf_r    <= res_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = out_occ_r;
  assign out_cell_log_odds = out_lo_r;
  assign out_cells_updated = out_cnt_r;
  assign out_overflow_seen = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_C)
    else $error("Touched count exceeds the list depth.");

  a_hit_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == logrid_pkg::S_HIT |-> $past(state_r) == logrid_pkg::S_MISS)
    else $error("Hit step was not preceded by the miss step.");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> out_valid_r && state_r == logrid_pkg::S_IDLE)
    else $error("A finished result did not reach the output register.");

endmodule

`default_nettype wire
